// ===== hdl/rdsc_pkg.sv =====
package rdsc_pkg;

    // character codes that may not stand in the alphabet
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // radix limits and register widths
    localparam int unsigned MAX_RADIX   = 16;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned ALPHA_W     = 64;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned UPC_W       = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    // reset values: radix ten, alphabet "0123456789abcdef"
    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665_6463_6261_3938;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CHECK,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_STORE,
        OP_RDINIT,
        OP_RDNEXT,
        OP_EMIT,
        OP_ERROR
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_IDLE,
        COND_CHK_MORE,
        COND_BAD,
        COND_DIV_MORE,
        COND_QUOT_NZ,
        COND_EMIT_MORE,
        COND_ALWAYS
    } cond_t;

    // one control word of the program
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [UPC_W-1:0]  target;
    } ctl_word_t;

    // flags from the datapath that the program branches on
    typedef struct packed {
        logic chk_more;
        logic bad;
        logic div_more;
        logic quot_nz;
        logic emit_more;
    } dp_status_t;

    // character i of the alphabet, character 0 in the lowest byte
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [2*ALPHA_W-1:0] alphabet,
        input logic [DIGIT_W-1:0]   idx
    );
        alpha_char = alphabet[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

// ===== hdl/rdsc_sequencer.sv =====
module rdsc_sequencer
    import rdsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctl_word_t  ctl,
    output logic       busy
);

    // program step addresses
    localparam logic [UPC_W-1:0] S_IDLE    = 4'd0;
    localparam logic [UPC_W-1:0] S_CHECK   = 4'd1;
    localparam logic [UPC_W-1:0] S_VERDICT = 4'd2;
    localparam logic [UPC_W-1:0] S_DIVINIT = 4'd3;
    localparam logic [UPC_W-1:0] S_DIVSTEP = 4'd4;
    localparam logic [UPC_W-1:0] S_STORE   = 4'd5;
    localparam logic [UPC_W-1:0] S_RDINIT  = 4'd6;
    localparam logic [UPC_W-1:0] S_RDNEXT  = 4'd7;
    localparam logic [UPC_W-1:0] S_EMIT    = 4'd8;
    localparam logic [UPC_W-1:0] S_TAIL    = 4'd9;
    localparam logic [UPC_W-1:0] S_ERROR   = 4'd10;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    // control store
    always_comb
    begin
        unique case (upc_reg)
            S_IDLE:    ctl = '{OP_LOAD,    COND_IDLE,      S_IDLE};
            S_CHECK:   ctl = '{OP_CHECK,   COND_CHK_MORE,  S_CHECK};
            S_VERDICT: ctl = '{OP_NOP,     COND_BAD,       S_ERROR};
            S_DIVINIT: ctl = '{OP_DIVINIT, COND_NEVER,     S_IDLE};
            S_DIVSTEP: ctl = '{OP_DIVSTEP, COND_DIV_MORE,  S_DIVSTEP};
            S_STORE:   ctl = '{OP_STORE,   COND_QUOT_NZ,   S_DIVINIT};
            S_RDINIT:  ctl = '{OP_RDINIT,  COND_NEVER,     S_IDLE};
            S_RDNEXT:  ctl = '{OP_RDNEXT,  COND_NEVER,     S_IDLE};
            S_EMIT:    ctl = '{OP_EMIT,    COND_EMIT_MORE, S_EMIT};
            S_TAIL:    ctl = '{OP_NOP,     COND_ALWAYS,    S_IDLE};
            S_ERROR:   ctl = '{OP_ERROR,   COND_ALWAYS,    S_IDLE};
            default:   ctl = '{OP_NOP,     COND_ALWAYS,    S_IDLE};
        endcase
    end

    // condition select
    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_IDLE:      jump = !start;
            COND_CHK_MORE:  jump = status.chk_more;
            COND_BAD:       jump = status.bad;
            COND_DIV_MORE:  jump = status.div_more;
            COND_QUOT_NZ:   jump = status.quot_nz;
            COND_EMIT_MORE: jump = status.emit_more;
            COND_ALWAYS:    jump = 1'b1;
            default:        jump = 1'b1;
        endcase
    end

    // step counter
    assign upc_next = jump ? ctl.target : upc_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign busy = (upc_reg != S_IDLE);

endmodule

// ===== hdl/rdsc_datapath.sv =====
module rdsc_datapath
    import rdsc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ALPHA_W-1:0]     cfg_data,
    input  logic [VALUE_WIDTH-1:0] value,
    input  ctl_word_t              ctl,
    output dp_status_t             status,
    output logic                   strobe,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last_digit,
    output logic                   alphabet_bad,
    output logic [COUNT_W-1:0]     digit_count
);

    localparam int unsigned AW    = $clog2(VALUE_WIDTH);
    localparam int unsigned DEPTH = 2 ** AW;

    // configuration
    logic [RADIX_W-1:0]   radix_reg;
    logic [ALPHA_W-1:0]   alpha_low_reg;
    logic [ALPHA_W-1:0]   alpha_high_reg;
    logic [2*ALPHA_W-1:0] alphabet;

    // control state
    logic [DIGIT_W-1:0] chk_idx_reg;
    logic               bad_reg;
    logic [AW-1:0]      bit_cnt_reg;
    logic [COUNT_W-1:0] digit_index_reg;
    logic [COUNT_W-1:0] emit_cnt_reg;
    logic               strobe_reg;

    // payload
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [DIGIT_W-1:0]     rdata_reg;
    logic [DIGIT_W-1:0]     digit_mem [DEPTH];
    logic [CHAR_W-1:0]      digit_char_reg;
    logic                   last_digit_reg;
    logic                   alphabet_bad_reg;
    logic [COUNT_W-1:0]     digit_count_reg;

    // combinational helpers
    logic               range_ok;
    logic [CHAR_W-1:0]  cur_char;
    logic [MAX_RADIX-1:0] dup_hit;
    logic               char_bad;
    logic [RADIX_W-1:0] rem_shift;
    logic               rem_ge;
    logic [RADIX_W-1:0] rem_next;
    logic [COUNT_W-1:0] emit_cnt_next;
    logic [CHAR_W-1:0]  emit_char;

    assign alphabet = {alpha_high_reg, alpha_low_reg};
    assign range_ok = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));

    // alphabet check of one character against all later ones in use
    assign cur_char = alpha_char(alphabet, chk_idx_reg);

    always_comb
    begin
        for (int j = 0; j < MAX_RADIX; j++)
        begin
            dup_hit[j] = (DIGIT_W'(j) > chk_idx_reg) && (RADIX_W'(j) < radix_reg)
                && (alpha_char(alphabet, DIGIT_W'(j)) == cur_char);
        end
    end

    assign char_bad = (cur_char == CHAR_MINUS) || (cur_char == CHAR_PLUS) || (|dup_hit);

    // one bit of restoring division by the radix
    assign rem_shift = {rem_reg[DIGIT_W-1:0], value_reg[VALUE_WIDTH-1]};
    assign rem_ge    = (rem_shift >= radix_reg);
    assign rem_next  = rem_ge ? rem_shift - radix_reg : rem_shift;

    // digit emission
    assign emit_cnt_next = emit_cnt_reg + COUNT_W'(1);
    assign emit_char     = alpha_char(alphabet, rdata_reg);

    // branch flags
    assign status.chk_more  = range_ok && ({1'b0, chk_idx_reg} != radix_reg - RADIX_W'(1));
    assign status.bad       = bad_reg;
    assign status.div_more  = (bit_cnt_reg != AW'(VALUE_WIDTH - 1));
    assign status.quot_nz   = (value_reg != '0);
    assign status.emit_more = (emit_cnt_next != digit_index_reg);

    // configuration registers and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            alpha_low_reg   <= ALPHA_LOW_RESET;
            alpha_high_reg  <= ALPHA_HIGH_RESET;
            chk_idx_reg     <= '0;
            bad_reg         <= 1'b0;
            bit_cnt_reg     <= '0;
            digit_index_reg <= '0;
            emit_cnt_reg    <= '0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                    REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                    REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                    default:        ;
                endcase
            end
            strobe_reg <= (ctl.op == OP_EMIT) || (ctl.op == OP_ERROR);
            unique case (ctl.op)
                OP_LOAD:
                begin
                    chk_idx_reg     <= '0;
                    bad_reg         <= !range_ok;
                    digit_index_reg <= '0;
                end
                OP_CHECK:
                begin
                    chk_idx_reg <= chk_idx_reg + DIGIT_W'(1);
                    bad_reg     <= bad_reg || char_bad;
                end
                OP_DIVINIT: bit_cnt_reg <= '0;
                OP_DIVSTEP: bit_cnt_reg <= bit_cnt_reg + AW'(1);
                OP_STORE:   digit_index_reg <= digit_index_reg + COUNT_W'(1);
                OP_RDINIT:  emit_cnt_reg <= '0;
                OP_EMIT:    emit_cnt_reg <= emit_cnt_next;
                default:    ;
            endcase
        end
    end

    // value, remainder, digit store and result fields
    always_ff @(posedge clk)
    begin
        rdata_reg <= digit_mem[rd_addr_reg];
        unique case (ctl.op)
            OP_LOAD:    value_reg <= value;
            OP_DIVINIT: rem_reg <= '0;
            OP_DIVSTEP:
            begin
                rem_reg   <= rem_next;
                value_reg <= {value_reg[VALUE_WIDTH-2:0], rem_ge};
            end
            OP_STORE:   digit_mem[digit_index_reg[AW-1:0]] <= rem_reg[DIGIT_W-1:0];
            OP_RDINIT:  rd_addr_reg <= AW'(digit_index_reg - COUNT_W'(1));
            OP_RDNEXT:  rd_addr_reg <= rd_addr_reg - AW'(1);
            OP_EMIT:
            begin
                rd_addr_reg      <= rd_addr_reg - AW'(1);
                digit_char_reg   <= emit_char;
                last_digit_reg   <= !status.emit_more;
                alphabet_bad_reg <= 1'b0;
                digit_count_reg  <= digit_index_reg;
            end
            OP_ERROR:
            begin
                digit_char_reg   <= '0;
                last_digit_reg   <= 1'b1;
                alphabet_bad_reg <= 1'b1;
                digit_count_reg  <= '0;
            end
            default: ;
        endcase
    end

    assign strobe       = strobe_reg;
    assign digit_char   = digit_char_reg;
    assign last_digit   = last_digit_reg;
    assign alphabet_bad = alphabet_bad_reg;
    assign digit_count  = digit_count_reg;

endmodule

// ===== hdl/radix_digit_string_converter.sv =====
// Converts an unsigned value to a string of digit characters in a radix of 2 to 16,
// most significant digit first, with one transaction on the result ports per digit
// (strobe high for one cycle; the receiver cannot stall, so every strobe must be taken).
// An item is taken when start is high and busy is low. The alphabet is checked first,
// one character per cycle (only the first character when the radix is out of range);
// a sign character, a repeat or a radix out of range gives one error transaction instead.
// Each digit then comes out of the bit-serial divider, after which the digits are
// read back out of the digit store one per cycle.
// Write the configuration only while busy is low: a write is taken at once, so a write
// during a conversion changes the digits of that conversion.
module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ALPHA_W-1:0]     cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   strobe,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last_digit,
    output logic                   alphabet_bad,
    output logic [COUNT_W-1:0]     digit_count
);

    ctl_word_t  ctl;
    dp_status_t status;

    // program sequencer
    rdsc_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    // divider, alphabet check and digit store
    rdsc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .value        (value),
        .ctl          (ctl),
        .status       (status),
        .strobe       (strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .alphabet_bad (alphabet_bad),
        .digit_count  (digit_count)
    );

endmodule

// ===== hdl/rdsc_checker.sv =====
module rdsc_checker
    import rdsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input logic [CHAR_W-1:0]  digit_char,
    input logic               last_digit,
    input logic               alphabet_bad,
    input logic [COUNT_W-1:0] digit_count
);

    // a taken item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // digits of one conversion come out in consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_digit) |=> (strobe && !alphabet_bad
            && digit_count == $past(digit_count)))
        else $error("gap or count change inside a digit string");

    // the error transaction is a single, empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && alphabet_bad) |-> (last_digit && digit_count == '0 && digit_char == '0))
        else $error("malformed alphabet error transaction");

    // a good conversion has at least one digit
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !alphabet_bad) |-> (digit_count != '0))
        else $error("digit transaction with zero count");

    // the last transaction of an item is not followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_digit) |=> !strobe)
        else $error("transaction right after the last one");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .strobe       (strobe),
    .digit_char   (digit_char),
    .last_digit   (last_digit),
    .alphabet_bad (alphabet_bad),
    .digit_count  (digit_count)
);
